### rtl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the RGB 3x3 convolution filter
// Holds the request and result item types, the pixel and window types, the
// register indexes, the kernel mode codes and the configuration reset values.
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int ROW_W      = 14;
    localparam int HEIGHT_W   = 13;
    localparam int WIDTH_W    = 11;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FIFO_DEPTH = 8;
    localparam int SUM_W      = 14;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BOX     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EMBOSS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd4;

    localparam logic [MODE_W-1:0]   RST_KERNEL_MODE  = MODE_BOX;
    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd768;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic       func;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic       fe;
        t_pix [8:0] nb;
    } t_win;

endpackage

### rtl/rcf_ram.sv
// ----------------------------------------------------------------------------
// rcf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data. A read at the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module rcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rcf_window.sv
// ----------------------------------------------------------------------------
// rcf_window: raster position tracking, line stores and 3x3 window
// Tracks the frame position, keeps the two previous rows in one RAM, shifts
// the window and presents the masked neighborhood of each due output pixel.
// ----------------------------------------------------------------------------
module rcf_window #(
    parameter int MAX_WIDTH = 1024,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [WW-1:0]                i_width,
    input  logic [rcf_pkg::HEIGHT_W-1:0] i_height,
    input  logic                         i_accept,
    input  rcf_pkg::t_in_item            i_data,
    output logic                         o_valid,
    output rcf_pkg::t_win                o_win,
    output logic [1:0]                   o_pending
);

    localparam int PW = $bits(rcf_pkg::t_pix);

    logic [XW-1:0]             r_x;
    logic [rcf_pkg::ROW_W-1:0] r_row;
    logic [XW-1:0]             n_x;
    logic [rcf_pkg::ROW_W-1:0] n_row;

    logic [rcf_pkg::ROW_W-1:0] h_ext;
    logic                      past;
    logic                      take;
    logic                      e1;
    logic                      e2;
    logic                      fe;
    logic [WW-1:0]             x_inc;

    logic                 r_s1_valid;
    logic                 r_s1_e1;
    logic                 r_s1_e2;
    logic                 r_s1_lok;
    logic                 r_s1_tok;
    logic                 r_s1_bok;
    logic                 r_s1_fe;
    logic                 r_s1_fwd;
    logic [XW-1:0]        r_s1_x;
    rcf_pkg::t_pix        r_s1_pix;
    logic [2*PW-1:0]      r_fwd_data;

    logic [2*PW-1:0]      ram_q;
    logic [2*PW-1:0]      line_q;
    logic [2*PW-1:0]      line_wdata;
    rcf_pkg::t_pix        up_pix;
    rcf_pkg::t_pix        mid_pix;
    rcf_pkg::t_pix [2:0]  new_col;

    rcf_pkg::t_pix        r_win [9];
    rcf_pkg::t_win        nb;

    logic                 r_s2_valid;
    rcf_pkg::t_win        r_s2_win;

    assign h_ext = rcf_pkg::ROW_W'(i_height);
    assign past  = r_row >= h_ext;
    assign take  = i_accept && !(i_data.func && !past);
    assign e1    = (r_x == '0) && (r_row >= rcf_pkg::ROW_W'(2));
    assign e2    = (r_x != '0) && (r_row != '0);
    assign fe    = e1 && (r_row == h_ext + rcf_pkg::ROW_W'(1));
    assign x_inc = WW'(r_x) + WW'(1);

    always_comb begin
        n_x   = r_x;
        n_row = r_row;
        if (i_restart) begin
            n_x   = '0;
            n_row = '0;
        end else if (take) begin
            if (fe) begin
                n_x   = '0;
                n_row = '0;
            end else if (x_inc >= i_width) begin
                n_x   = '0;
                n_row = r_row + rcf_pkg::ROW_W'(1);
            end else begin
                n_x = XW'(x_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_x        <= n_x;
            r_row      <= n_row;
            r_s1_valid <= take;
            r_s2_valid <= r_s1_valid && (r_s1_e1 || r_s1_e2);
        end
    end

    // The two neighbor flags are taken from the request position; the left
    // column is the first one of the row when the output column is zero.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_e1    <= e1;
            r_s1_e2    <= e2;
            r_s1_lok   <= e1 ? (i_width != WW'(1)) : (r_x != XW'(1));
            r_s1_tok   <= e1 ? (r_row != rcf_pkg::ROW_W'(2)) : (r_row != rcf_pkg::ROW_W'(1));
            r_s1_bok   <= e1 ? (r_row <= h_ext) : (r_row < h_ext);
            r_s1_fe    <= fe;
            r_s1_fwd   <= r_s1_valid && (r_s1_x == r_x);
            r_fwd_data <= line_wdata;
            r_s1_x     <= r_x;
            if (past) begin
                r_s1_pix <= '0;
            end else begin
                r_s1_pix <= {i_data.red_in, i_data.green_in, i_data.blue_in};
            end
        end
    end

    rcf_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_x),
        .i_wdata (line_wdata),
        .i_re    (take),
        .i_raddr (r_x),
        .o_rdata (ram_q)
    );

    assign line_q     = r_s1_fwd ? r_fwd_data : ram_q;
    assign up_pix     = line_q[2*PW-1:PW];
    assign mid_pix    = line_q[PW-1:0];
    assign line_wdata = {mid_pix, r_s1_pix};
    assign new_col[0] = up_pix;
    assign new_col[1] = mid_pix;
    assign new_col[2] = r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= r_win[k+3];
            end
            r_win[6] <= up_pix;
            r_win[7] <= mid_pix;
            r_win[8] <= r_s1_pix;
        end
    end

    always_comb begin
        logic row_ok;
        nb    = '0;
        nb.fe = r_s1_fe;
        for (int i = 0; i < 3; i++) begin
            row_ok = (i == 1) || ((i == 0) && r_s1_tok) || ((i == 2) && r_s1_bok);
            if (row_ok) begin
                if (r_s1_lok) begin
                    nb.nb[i*3] = r_win[3+i];
                end
                nb.nb[i*3+1] = r_win[6+i];
                if (r_s1_e2) begin
                    nb.nb[i*3+2] = new_col[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_win <= nb;
        end
    end

    assign o_valid   = r_s2_valid;
    assign o_win     = r_s2_win;
    assign o_pending = 2'(r_s1_valid) + 2'(r_s2_valid);

endmodule

### rtl/rcf_kernel.sv
// ----------------------------------------------------------------------------
// rcf_kernel: weighted sums, exact division and clamping
// Forms the nine-tap sum of each channel in one stage, then divides by the
// kernel's divisor and clamps the result to 0..255.
// ----------------------------------------------------------------------------
module rcf_kernel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rcf_pkg::t_win              i_win,
    input  logic [rcf_pkg::MODE_W-1:0] i_mode,
    output logic                       o_valid,
    output rcf_pkg::t_out_item         o_item
);

    localparam int SW = rcf_pkg::SUM_W;

    // Multiplying by this and dropping 16 bits divides by nine exactly for
    // every sum the box kernel can produce.
    localparam logic [12:0] BOX_RECIP = 13'd7282;

    localparam logic signed [4:0] TAPS [5][9] = '{
        '{5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1, 5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4, 5'sd2,  5'sd1,  5'sd2,  5'sd1},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{-5'sd2, -5'sd1, 5'sd0,  -5'sd1, 5'sd1, 5'sd1,  5'sd0,  5'sd1,  5'sd2},
        '{5'sd0,  -5'sd1, 5'sd0,  -5'sd1, 5'sd5, -5'sd1, 5'sd0,  -5'sd1, 5'sd0}
    };

    logic [rcf_pkg::MODE_W-1:0] mode_eff;
    logic signed [SW-1:0]       sum_r;
    logic signed [SW-1:0]       sum_g;
    logic signed [SW-1:0]       sum_b;

    logic                       r_valid;
    logic [rcf_pkg::MODE_W-1:0] r_mode;
    logic                       r_fe;
    logic signed [SW-1:0]       r_sum_r;
    logic signed [SW-1:0]       r_sum_g;
    logic signed [SW-1:0]       r_sum_b;

    function automatic logic [7:0] div_clamp(input logic signed [SW-1:0] s,
                                             input logic [rcf_pkg::MODE_W-1:0] mode);
        logic [24:0]   prod;
        logic [SW-1:0] q;
        prod = 25'(s[11:0]) * 25'(BOX_RECIP);
        case (mode)
            rcf_pkg::MODE_BOX: begin
                q = SW'(prod[24:16]);
            end
            rcf_pkg::MODE_GAUSS: begin
                q = SW'(s[SW-1:4]);
            end
            default: begin
                q = s;
            end
        endcase
        if (s[SW-1]) begin
            return 8'd0;
        end else if (q > SW'(255)) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    assign mode_eff = (i_mode > rcf_pkg::MODE_SHARPEN) ? rcf_pkg::MODE_BOX : i_mode;

    always_comb begin
        logic signed [SW-1:0] wt;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 9; k++) begin
            wt    = SW'(TAPS[mode_eff][k]);
            sum_r = sum_r + wt * $signed(SW'(i_win.nb[k].red));
            sum_g = sum_g + wt * $signed(SW'(i_win.nb[k].green));
            sum_b = sum_b + wt * $signed(SW'(i_win.nb[k].blue));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_mode  <= mode_eff;
            r_fe    <= i_win.fe;
            r_sum_r <= sum_r;
            r_sum_g <= sum_g;
            r_sum_b <= sum_b;
        end
    end

    assign o_valid          = r_valid;
    assign o_item.red_out   = div_clamp(r_sum_r, r_mode);
    assign o_item.green_out = div_clamp(r_sum_g, r_mode);
    assign o_item.blue_out  = div_clamp(r_sum_b, r_mode);
    assign o_item.frame_end = r_fe;

endmodule

### rtl/rcf_fifo.sv
// ----------------------------------------------------------------------------
// rcf_fifo: result queue
// Small flip-flop queue that holds finished results until they are taken,
// so that the input side keeps running while the output side stalls.
// ----------------------------------------------------------------------------
module rcf_fifo (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_push,
    input  rcf_pkg::t_out_item                       i_data,
    input  logic                                     i_pop,
    output logic                                     o_valid,
    output rcf_pkg::t_out_item                       o_data,
    output logic [$clog2(rcf_pkg::FIFO_DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(rcf_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(rcf_pkg::FIFO_DEPTH + 1);

    rcf_pkg::t_out_item r_mem [rcf_pkg::FIFO_DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic               pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/rgb_conv3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter: streaming 3x3 convolution filter for RGB pixels
// Filters a raster stream of pixels with a box, Gaussian, outline, emboss or
// sharpen kernel; neighbors outside the frame count as zero.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------
//  request  | i_valid / o_ready  | i_data: func, red_in, green_in, blue_in
//  result   | o_valid / i_ready  | o_data: red_out, green_out, blue_out,
//           |                    |         frame_end
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  One request is taken per clock while o_ready is high. A result passes the
//  line RAM read, window, tap sums, divide and clamp into an eight-entry result
//  queue before it is offered. o_ready drops when the queue and the stages in
//  flight hold eight items. Reset clears the frame position and the queue;
//  line RAM and window contents need no clearing.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  rcf_pkg::t_in_item              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output rcf_pkg::t_out_item             o_data,
    input  logic                           i_cfg_we,
    input  logic [rcf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > rcf_pkg::WIDTH_W) ? WW : rcf_pkg::WIDTH_W;
    localparam int FCW = $clog2(rcf_pkg::FIFO_DEPTH + 1);
    localparam int OCW = FCW + 1;

    logic [rcf_pkg::MODE_W-1:0]   r_mode;
    logic [rcf_pkg::WIDTH_W-1:0]  r_width;
    logic [rcf_pkg::HEIGHT_W-1:0] r_height;

    logic                         restart;
    logic [EW-1:0]                width_ext;
    logic [WW-1:0]                width_eff;
    logic [rcf_pkg::HEIGHT_W-1:0] height_eff;

    logic                         accept;
    logic                         win_valid;
    rcf_pkg::t_win                win;
    logic [1:0]                   pending;
    logic                         res_valid;
    rcf_pkg::t_out_item           res_item;
    logic [FCW-1:0]               fifo_count;
    logic [OCW-1:0]               occupied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rcf_pkg::RST_KERNEL_MODE;
            r_width  <= rcf_pkg::RST_IMAGE_WIDTH;
            r_height <= rcf_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcf_pkg::REG_KERNEL_MODE: begin
                    r_mode <= i_cfg_data[rcf_pkg::MODE_W-1:0];
                end
                rcf_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[rcf_pkg::WIDTH_W-1:0];
                end
                rcf_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[rcf_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign restart = i_cfg_we && ((i_cfg_idx == rcf_pkg::REG_IMAGE_WIDTH)
                               || (i_cfg_idx == rcf_pkg::REG_IMAGE_HEIGHT));

    assign width_ext = EW'(r_width);

    always_comb begin
        if (width_ext == '0) begin
            width_eff = WW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_ext);
        end
    end

    assign height_eff = (r_height == '0) ? rcf_pkg::HEIGHT_W'(1) : r_height;

    assign occupied = OCW'(fifo_count) + OCW'(pending) + OCW'(res_valid);
    assign o_ready  = occupied < OCW'(rcf_pkg::FIFO_DEPTH);
    assign accept   = i_valid && o_ready;

    rcf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_width   (width_eff),
        .i_height  (height_eff),
        .i_accept  (accept),
        .i_data    (i_data),
        .o_valid   (win_valid),
        .o_win     (win),
        .o_pending (pending)
    );

    rcf_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .i_win   (win),
        .i_mode  (r_mode),
        .o_valid (res_valid),
        .o_item  (res_item)
    );

    rcf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_item),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_count (fifo_count)
    );

endmodule
